// File: src/codec_index_regs_pcm_playback_macros.svh
// Assertion macros shared by the codec register block.
`ifndef CODEC_INDEX_REGS_PCM_PLAYBACK_MACROS_SVH
`define CODEC_INDEX_REGS_PCM_PLAYBACK_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define CIRP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define CIRP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/cirp_pkg.sv
// Types, register codes and constant tables of the codec register block.
`timescale 1ns / 1ps

package cirp_pkg;

	// Register file geometry.
	localparam int REG_COUNT = 32;
	localparam int IDX_W     = $clog2(REG_COUNT);
	localparam int VOL_STEPS = 64;
	localparam int VOL_W     = $clog2(VOL_STEPS);
	localparam int GAIN_W    = 17;
	localparam int CNT_W     = 17;

	// Request kinds.
	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NOP   = 2'd3
	} req_kind_t;

	// Bus ports.
	typedef enum logic [1:0] {
		PORT_INDEX  = 2'd0,
		PORT_DATA   = 2'd1,
		PORT_STATUS = 2'd2,
		PORT_UNUSED = 2'd3
	} port_sel_t;

	// Indexed register numbers.
	localparam logic [IDX_W-1:0] REG_LDAC  = 5'd6;
	localparam logic [IDX_W-1:0] REG_RDAC  = 5'd7;
	localparam logic [IDX_W-1:0] REG_DFS   = 5'd8;
	localparam logic [IDX_W-1:0] REG_ITF   = 5'd9;
	localparam logic [IDX_W-1:0] REG_PIN   = 5'd10;
	localparam logic [IDX_W-1:0] REG_TEST  = 5'd11;
	localparam logic [IDX_W-1:0] REG_MODE  = 5'd12;
	localparam logic [IDX_W-1:0] REG_UBASE = 5'd14;
	localparam logic [IDX_W-1:0] REG_LBASE = 5'd15;
	localparam logic [IDX_W-1:0] REG_ALT   = 5'd24;

	// Data format codes after masking.
	localparam logic [7:0] FMT_U8_MONO     = 8'h00;
	localparam logic [7:0] FMT_U8_STEREO   = 8'h10;
	localparam logic [7:0] FMT_S16_MONO    = 8'h40;
	localparam logic [7:0] FMT_S16_STEREO  = 8'h50;
	localparam logic [7:0] FMT_S16B_MONO   = 8'hc0;
	localparam logic [7:0] FMT_S16B_STEREO = 8'hd0;
	localparam logic [7:0] FMT_MASK_MODE1  = 8'h70;
	localparam logic [7:0] FMT_MASK_MODE2  = 8'hf0;

	// Miscellaneous bit patterns.
	localparam int         MODE2_BIT    = 6;
	localparam int         MUTE_BIT     = 7;
	localparam int         IRQ_EN_BIT   = 1;
	localparam logic [7:0] MODE_FORCE   = 8'h8a;
	localparam logic [7:0] PLAY_MASK    = 8'h41;
	localparam logic [7:0] PLAY_ON      = 8'h01;
	localparam logic [7:0] ALT_MASK     = 8'h70;
	localparam logic [7:0] STATUS_BASE  = 8'hcc;
	localparam logic [7:0] INIT_READ    = 8'h80;
	localparam logic [7:0] UNUSED_READ  = 8'hff;
	localparam logic [7:0] TEST_TOGGLE  = 8'h20;
	localparam logic [7:0] SIGN_FLIP    = 8'h80;

	// One request item.
	typedef struct packed {
		req_kind_t   req_type;
		port_sel_t   port;
		logic [7:0]  write_data;
		logic [31:0] dma_bytes;
	} req_item_t;

	// One result item.
	typedef struct packed {
		logic [7:0]         read_data;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [2:0]         dma_used;
		logic               irq_pulse;
	} rsp_item_t;

	// Value an indexed register holds before its first write.
	function automatic logic [7:0] reg_reset_value(input logic [IDX_W-1:0] idx);
		logic [7:0] v;
		case (idx) inside
			5'd2, 5'd3, 5'd4, 5'd5, 5'd18, 5'd19: v = 8'h88;
			5'd6, 5'd7, 5'd22, 5'd25, 5'd26, 5'd29: v = 8'h80;
			5'd9:  v = 8'h08;
			5'd12: v = 8'h8a;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Attenuation gain, 3 dB per step, unity at 65536.
	function automatic logic [GAIN_W-1:0] vol_gain(input logic [VOL_W-1:0] c);
		logic [GAIN_W-1:0] g;
		case (c)
			6'd0:  g = 17'd65536;
			6'd1:  g = 17'd46395;
			6'd2:  g = 17'd32845;
			6'd3:  g = 17'd23253;
			6'd4:  g = 17'd16461;
			6'd5:  g = 17'd11654;
			6'd6:  g = 17'd8250;
			6'd7:  g = 17'd5840;
			6'd8:  g = 17'd4135;
			6'd9:  g = 17'd2927;
			6'd10: g = 17'd2072;
			6'd11: g = 17'd1467;
			6'd12: g = 17'd1038;
			6'd13: g = 17'd735;
			6'd14: g = 17'd520;
			6'd15: g = 17'd368;
			6'd16: g = 17'd260;
			6'd17: g = 17'd184;
			6'd18: g = 17'd130;
			6'd19: g = 17'd92;
			6'd20: g = 17'd65;
			6'd21: g = 17'd46;
			6'd22: g = 17'd32;
			6'd23: g = 17'd23;
			6'd24: g = 17'd16;
			6'd25: g = 17'd11;
			6'd26: g = 17'd8;
			6'd27: g = 17'd5;
			6'd28: g = 17'd4;
			6'd29: g = 17'd2;
			6'd30: g = 17'd2;
			6'd31: g = 17'd1;
			6'd32: g = 17'd1;
			default: g = 17'd0;
		endcase
		return g;
	endfunction

endpackage

// File: src/codec_index_regs_pcm_playback.sv
// Indexed codec register block with an attenuated PCM playback path.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  req     | in        | req_valid/req_stall | bus read, bus write or tick
//  rsp     | out       | rsp_valid/rsp_stall | read byte, samples, dma, irq
//
// One item is accepted per cycle while req_stall is low; its result passes through
// the registered read of the register memory in the read stage, then the output register.
// All architectural state, the register memory included, is updated at the accept
// edge, so back-to-back items always see the effect of the item before them.
// arst_n resets all control state; per-entry valid bits make unwritten memory
// entries read as their reset values, so no clearing pass is needed.
// With rsp stalled, one more item is taken into the read stage before req
// stalls.

`include "codec_index_regs_pcm_playback_macros.svh"

module codec_index_regs_pcm_playback (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  cirp_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output cirp_pkg::rsp_item_t  rsp
);

	localparam int IDX_W = cirp_pkg::IDX_W;
	localparam int CNT_W = cirp_pkg::CNT_W;

	// Architectural state.
	logic [IDX_W-1:0]     index_q, index_d;
	logic                 trd_q, trd_d, mce_q, mce_d, ia4_q, ia4_d, init_q, init_d;
	logic                 play_en_q, play_en_d;
	logic                 st_irq_q, st_irq_d;
	logic [CNT_W-1:0]     counter_q, counter_d, cnt_tmp;
	logic signed [15:0]   lhold_q, lhold_d, rhold_q, rhold_d;

	// Copies of the registers that the datapath reads every cycle.
	logic [7:0] ldac_q, ldac_d, rdac_q, rdac_d, dfs_q, dfs_d, pin_q, pin_d;
	logic [7:0] test_q, test_d, mode_q, mode_d, ubase_q, ubase_d, lbase_q, lbase_d;

	// Register memory and its valid bits.
	logic [7:0]                     mem [cirp_pkg::REG_COUNT];
	logic [cirp_pkg::REG_COUNT-1:0] vld_q;
	logic                           mem_we;
	logic [7:0]                     mem_wd;

	// Read stage and output register.
	logic               s1_valid_q;
	logic               mem_rd_s1, vld_s1;
	logic [7:0]         rdata_s1, init_s1, rd_s1;
	logic signed [15:0] left_s1, right_s1;
	logic [2:0]         used_s1;
	logic               irq_s1;
	logic               out_valid_q;
	cirp_pkg::rsp_item_t rsp_q;

	// Per-item combinational results.
	logic               accept, s1_adv, mode2;
	logic [7:0]         rd_val, wv, fmt, status;
	logic               rd_from_mem;
	logic [2:0]         used;
	logic               irq;
	logic signed [15:0] l_raw, r_raw, att_l, att_r;
	logic signed [33:0] prod_l, prod_r;
	logic [7:0]         rd_final_s1;

	// Handshake between the stages.
	assign s1_adv    = s1_valid_q && (!out_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && !s1_adv;
	assign accept    = req_valid && !req_stall;
	assign mode2     = mode_q[cirp_pkg::MODE2_BIT];
	assign status    = cirp_pkg::STATUS_BASE | {7'd0, st_irq_q};

	// Sample formatting of the DMA bytes.
	always_comb begin
		l_raw = lhold_q;
		r_raw = rhold_q;
		used  = 3'd0;
		fmt   = mode2 ? (dfs_q & cirp_pkg::FMT_MASK_MODE2) : (dfs_q & cirp_pkg::FMT_MASK_MODE1);
		case (fmt) inside
			cirp_pkg::FMT_U8_MONO: begin
				l_raw = $signed({req.dma_bytes[7:0] ^ cirp_pkg::SIGN_FLIP, 8'd0});
				r_raw = l_raw;
				used  = 3'd1;
			end
			cirp_pkg::FMT_U8_STEREO: begin
				l_raw = $signed({req.dma_bytes[7:0] ^ cirp_pkg::SIGN_FLIP, 8'd0});
				r_raw = $signed({req.dma_bytes[15:8] ^ cirp_pkg::SIGN_FLIP, 8'd0});
				used  = 3'd2;
			end
			cirp_pkg::FMT_S16_MONO, cirp_pkg::FMT_S16B_MONO: begin
				l_raw = $signed(req.dma_bytes[15:0]);
				r_raw = l_raw;
				used  = 3'd2;
			end
			cirp_pkg::FMT_S16_STEREO, cirp_pkg::FMT_S16B_STEREO: begin
				l_raw = $signed(req.dma_bytes[15:0]);
				r_raw = $signed(req.dma_bytes[31:16]);
				used  = 3'd4;
			end
			default: begin
			end
		endcase
	end

	// Attenuation: the product shifted right by 16 with floor rounding.
	assign prod_l = l_raw * $signed({1'b0, cirp_pkg::vol_gain(ldac_q[cirp_pkg::VOL_W-1:0])});
	assign prod_r = r_raw * $signed({1'b0, cirp_pkg::vol_gain(rdac_q[cirp_pkg::VOL_W-1:0])});
	assign att_l  = ldac_q[cirp_pkg::MUTE_BIT] ? 16'sd0 : prod_l[31:16];
	assign att_r  = rdac_q[cirp_pkg::MUTE_BIT] ? 16'sd0 : prod_r[31:16];

	// Next state of the registers for the accepted item.
	always_comb begin
		index_d     = index_q;
		trd_d       = trd_q;
		mce_d       = mce_q;
		ia4_d       = ia4_q;
		init_d      = init_q;
		play_en_d   = play_en_q;
		st_irq_d    = st_irq_q;
		counter_d   = counter_q;
		cnt_tmp     = counter_q;
		lhold_d     = lhold_q;
		rhold_d     = rhold_q;
		ldac_d      = ldac_q;
		rdac_d      = rdac_q;
		dfs_d       = dfs_q;
		pin_d       = pin_q;
		test_d      = test_q;
		mode_d      = mode_q;
		ubase_d     = ubase_q;
		lbase_d     = lbase_q;
		mem_we      = 1'b0;
		wv          = (index_q == cirp_pkg::REG_MODE) ?
			(req.write_data | cirp_pkg::MODE_FORCE) : req.write_data;
		mem_wd      = wv;
		rd_val      = 8'd0;
		rd_from_mem = 1'b0;
		irq         = 1'b0;
		if (accept) begin
			case (req.req_type)
				cirp_pkg::REQ_READ: begin
					if (init_q) begin
						rd_val = cirp_pkg::INIT_READ;
					end else begin
						case (req.port)
							cirp_pkg::PORT_INDEX: begin
								rd_val = {1'b0, mce_q, trd_q, 5'd0} | 8'(index_q) |
									(mode2 ? {3'd0, ia4_q, 4'd0} : 8'd0);
							end
							cirp_pkg::PORT_DATA: begin
								// The test register toggles its bit 5 on every data-port read while init is clear.
								if (index_q == cirp_pkg::REG_TEST) begin
									test_d = test_q ^ cirp_pkg::TEST_TOGGLE;
									rd_val = test_d;
								end else begin
									rd_from_mem = 1'b1;
								end
							end
							cirp_pkg::PORT_STATUS: rd_val = status;
							default: rd_val = cirp_pkg::UNUSED_READ;
						endcase
					end
				end
				cirp_pkg::REQ_WRITE: begin
					case (req.port)
						cirp_pkg::PORT_INDEX: begin
							index_d = mode2 ? req.write_data[IDX_W-1:0] :
								{1'b0, req.write_data[IDX_W-2:0]};
							ia4_d  = req.write_data[4];
							trd_d  = req.write_data[5];
							mce_d  = req.write_data[6];
							init_d = req.write_data[7];
						end
						cirp_pkg::PORT_DATA: begin
							mem_we = 1'b1;
							case (index_q)
								cirp_pkg::REG_LDAC:  ldac_d = wv;
								cirp_pkg::REG_RDAC:  rdac_d = wv;
								cirp_pkg::REG_DFS:   dfs_d  = wv;
								cirp_pkg::REG_ITF: begin
									play_en_d = (wv & cirp_pkg::PLAY_MASK) == cirp_pkg::PLAY_ON;
									if (!play_en_d) begin
										lhold_d = 16'sd0;
										rhold_d = 16'sd0;
									end
								end
								cirp_pkg::REG_PIN:   pin_d  = wv;
								cirp_pkg::REG_TEST:  test_d = wv;
								cirp_pkg::REG_MODE:  mode_d = wv;
								cirp_pkg::REG_UBASE: begin
									ubase_d   = wv;
									counter_d = {1'b0, wv, lbase_q};
								end
								cirp_pkg::REG_LBASE: lbase_d = wv;
								cirp_pkg::REG_ALT: begin
									if ((wv & cirp_pkg::ALT_MASK) == 8'd0) begin
										st_irq_d = 1'b0;
									end
								end
								default: begin
								end
							endcase
						end
						cirp_pkg::PORT_STATUS: st_irq_d = 1'b0;
						default: begin
						end
					endcase
				end
				cirp_pkg::REQ_TICK: begin
					if (!play_en_q) begin
						lhold_d = 16'sd0;
						rhold_d = 16'sd0;
					end else begin
						lhold_d = att_l;
						rhold_d = att_r;
						// Playback counter: reload and flag once it has gone negative.
						if (counter_q[CNT_W-1]) begin
							cnt_tmp = {1'b0, ubase_q, lbase_q};
							if (!st_irq_q) begin
								st_irq_d = 1'b1;
								irq      = pin_q[cirp_pkg::IRQ_EN_BIT];
							end
						end
						counter_d = cnt_tmp - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Control and shadow registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q   <= '0;
			trd_q     <= 1'b0;
			mce_q     <= 1'b1;
			ia4_q     <= 1'b0;
			init_q    <= 1'b0;
			play_en_q <= 1'b0;
			st_irq_q  <= 1'b0;
			counter_q <= '0;
			lhold_q   <= 16'sd0;
			rhold_q   <= 16'sd0;
			ldac_q    <= cirp_pkg::reg_reset_value(cirp_pkg::REG_LDAC);
			rdac_q    <= cirp_pkg::reg_reset_value(cirp_pkg::REG_RDAC);
			dfs_q     <= cirp_pkg::reg_reset_value(cirp_pkg::REG_DFS);
			pin_q     <= cirp_pkg::reg_reset_value(cirp_pkg::REG_PIN);
			test_q    <= cirp_pkg::reg_reset_value(cirp_pkg::REG_TEST);
			mode_q    <= cirp_pkg::reg_reset_value(cirp_pkg::REG_MODE);
			ubase_q   <= cirp_pkg::reg_reset_value(cirp_pkg::REG_UBASE);
			lbase_q   <= cirp_pkg::reg_reset_value(cirp_pkg::REG_LBASE);
			vld_q     <= '0;
		end else begin
			index_q   <= index_d;
			trd_q     <= trd_d;
			mce_q     <= mce_d;
			ia4_q     <= ia4_d;
			init_q    <= init_d;
			play_en_q <= play_en_d;
			st_irq_q  <= st_irq_d;
			counter_q <= counter_d;
			lhold_q   <= lhold_d;
			rhold_q   <= rhold_d;
			ldac_q    <= ldac_d;
			rdac_q    <= rdac_d;
			dfs_q     <= dfs_d;
			pin_q     <= pin_d;
			test_q    <= test_d;
			mode_q    <= mode_d;
			ubase_q   <= ubase_d;
			lbase_q   <= lbase_d;
			if (mem_we) begin
				vld_q[index_q] <= 1'b1;
			end
		end
	end

	// Register memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[index_q] <= mem_wd;
		end
		if (accept) begin
			rdata_s1 <= mem[index_q];
		end
	end

	// Read stage payload, loaded together with the memory read.
	always_ff @(posedge clk) begin
		if (accept) begin
			vld_s1    <= vld_q[index_q];
			init_s1   <= cirp_pkg::reg_reset_value(index_q);
			mem_rd_s1 <= rd_from_mem;
			rd_s1     <= rd_val;
			left_s1   <= lhold_d;
			right_s1  <= rhold_d;
			used_s1   <= (accept && req.req_type == cirp_pkg::REQ_TICK && play_en_q) ?
				used : 3'd0;
			irq_s1    <= irq;
		end
	end

	assign rd_final_s1 = mem_rd_s1 ? (vld_s1 ? rdata_s1 : init_s1) : rd_s1;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.read_data    <= rd_final_s1;
			rsp_q.left_sample  <= left_s1;
			rsp_q.right_sample <= right_s1;
			rsp_q.dma_used     <= used_s1;
			rsp_q.irq_pulse    <= irq_s1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// Checks on the pipeline and the playback state.
	`CIRP_ASSERT_IMPLY(a_stall_means_full, req_stall, s1_valid_q && out_valid_q && rsp_stall, "req stalled without a full pipeline")
	`CIRP_ASSERT_IMPLY(a_disabled_silent, !play_en_q, (lhold_q == 16'sd0) && (rhold_q == 16'sd0), "nonzero sample while playback is disabled")
	`CIRP_ASSERT_IMPLY(a_used_code, out_valid_q, (rsp_q.dma_used == 3'd0) || (rsp_q.dma_used == 3'd1) || (rsp_q.dma_used == 3'd2) || (rsp_q.dma_used == 3'd4), "invalid DMA byte count")

endmodule
